// File: src/mat_pkg.sv
// Package for the multi-turn angle tracker: constants, codes and the
// command and status structs shared by the controller and the datapath.
// Depends on nothing.
package mat_pkg;

  localparam int unsigned AngleW  = 12;
  localparam int unsigned RawW    = 16;
  localparam int unsigned DtW     = 24;
  localparam int unsigned TickW   = 32;
  localparam int unsigned DeltaW  = AngleW + 2;
  localparam int unsigned VelKW   = 27;
  localparam int unsigned DivBits = 38;
  localparam int unsigned CntW    = $clog2(DivBits);

  localparam logic [RawW-1:0]   AngleMax = 16'd4095;
  localparam logic [DtW-1:0]    DtMinUs  = 24'd1000;
  localparam logic [VelKW-1:0]  VelK     = 27'd100530965;
  localparam logic signed [DeltaW-1:0] HalfTurn = 14'sd2048;
  localparam logic signed [DeltaW-1:0] FullTurn = 14'sd4096;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdClear  = 1'b1;

  typedef struct packed {
    logic load_in;
    logic calc_delta;
    logic update;
    logic mul;
    logic add_half;
    logic div_step;
    logic apply_sign;
    logic load_out;
  } mat_cmd_t;

  typedef struct packed {
    logic vel_needed;
    logic div_last;
  } mat_stat_t;

endpackage

// File: src/mat_in_if.sv
// Request channel of the angle tracker: command, raw angle and interval.
// Depends on mat_pkg for the field widths.
interface mat_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [mat_pkg::RawW-1:0]     raw_angle;
  logic [mat_pkg::DtW-1:0]      dt_us;

  modport source (output valid, output cmd, output raw_angle, output dt_us, input ready);
  modport sink   (input valid, input cmd, input raw_angle, input dt_us, output ready);
endinterface

// File: src/mat_out_if.sv
// Result channel of the angle tracker: tick count, velocity and taken flag.
// Depends on mat_pkg for the field widths.
interface mat_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mat_pkg::TickW-1:0]   total_ticks;
  logic signed [mat_pkg::TickW-1:0]   velocity_q16;
  logic                               sample_taken;

  modport source (output valid, output total_ticks, output velocity_q16,
                  output sample_taken, input ready);
  modport sink   (input valid, input total_ticks, input velocity_q16,
                  input sample_taken, output ready);
endinterface

// File: src/multiturn_angle_tracker_unit.sv
// A clear, a failed read, a priming sample or a short interval runs the four-step
// sequence (accept, delta, update, finish); with velocity, the multiply, add-half,
// 38-step bit-serial divider and sign steps come before finish. A new request
// is taken only after the last one leaves finish. A finished result waits in
// the output register while the next request is taken.
// Reset (rst_ni, asynchronous, active low) clears the count, velocity,
// previous angle, priming flag and invert register.
module multiturn_angle_tracker_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  mat_in_if.sink       sample_i,
  mat_out_if.source    result_o,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i
);

  mat_pkg::mat_cmd_t  cmd;
  mat_pkg::mat_stat_t stat;

  mat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mat_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_cmd_i       (sample_i.cmd),
    .req_raw_angle_i (sample_i.raw_angle),
    .req_dt_us_i     (sample_i.dt_us),
    .total_ticks_o   (result_o.total_ticks),
    .velocity_q16_o  (result_o.velocity_q16),
    .sample_taken_o  (result_o.sample_taken)
  );

endmodule

// File: src/mat_dp.sv
// Datapath of the angle tracker: angle state, delta, multiplier, bit-serial
// divider and the output register. Driven by commands from mat_ctrl.
// Depends on mat_pkg.
module mat_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mat_pkg::mat_cmd_t                 cmd_i,
  output mat_pkg::mat_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              req_cmd_i,
  input  logic [mat_pkg::RawW-1:0]          req_raw_angle_i,
  input  logic [mat_pkg::DtW-1:0]           req_dt_us_i,
  output logic signed [mat_pkg::TickW-1:0]  total_ticks_o,
  output logic signed [mat_pkg::TickW-1:0]  velocity_q16_o,
  output logic                              sample_taken_o
);

  logic                                invert_q;
  logic                                cmd_q;
  logic [mat_pkg::RawW-1:0]            raw_q;
  logic [mat_pkg::DtW-1:0]             dt_q;
  logic [mat_pkg::AngleW-1:0]          prev_q;
  logic                                primed_q;
  logic [mat_pkg::TickW-1:0]           tick_q;
  logic [mat_pkg::TickW-1:0]           vel_q;
  logic                                taken_q;
  logic signed [mat_pkg::DeltaW-1:0]   delta_q;
  logic [mat_pkg::DivBits-1:0]         num_q;
  logic [mat_pkg::DtW-1:0]             rem_q;
  logic [mat_pkg::CntW-1:0]            cnt_q;
  logic signed [mat_pkg::TickW-1:0]    out_ticks_q;
  logic signed [mat_pkg::TickW-1:0]    out_vel_q;
  logic                                out_taken_q;

  logic                                raw_ok;
  logic signed [mat_pkg::DeltaW-1:0]   diff;
  logic signed [mat_pkg::DeltaW-1:0]   wrapped;
  logic signed [mat_pkg::DeltaW-1:0]   delta_d;
  logic [mat_pkg::DeltaW-1:0]          abs_delta;
  logic [mat_pkg::AngleW-1:0]          mag;
  logic [mat_pkg::DtW:0]               partial;
  logic [mat_pkg::DtW:0]               trial;
  logic                                fits;

  assign raw_ok = (raw_q <= mat_pkg::AngleMax);

  always_comb begin
    diff = $signed({{(mat_pkg::DeltaW-mat_pkg::AngleW){1'b0}}, raw_q[mat_pkg::AngleW-1:0]})
         - $signed({{(mat_pkg::DeltaW-mat_pkg::AngleW){1'b0}}, prev_q});
    if (diff > mat_pkg::HalfTurn) begin
      wrapped = diff - mat_pkg::FullTurn;
    end else if (diff < -mat_pkg::HalfTurn) begin
      wrapped = diff + mat_pkg::FullTurn;
    end else begin
      wrapped = diff;
    end
    delta_d = invert_q ? -wrapped : wrapped;
  end

  assign abs_delta = delta_q[mat_pkg::DeltaW-1] ? mat_pkg::DeltaW'(-delta_q)
                                                : mat_pkg::DeltaW'(delta_q);
  assign mag       = abs_delta[mat_pkg::AngleW-1:0];

  assign partial = {rem_q, num_q[mat_pkg::DivBits-1]};
  assign fits    = (partial >= {1'b0, dt_q});
  assign trial   = partial - {1'b0, dt_q};

  assign stat_o.vel_needed = (cmd_q == mat_pkg::CmdSample) && raw_ok && primed_q &&
                             (dt_q > mat_pkg::DtMinUs);
  assign stat_o.div_last   = (cnt_q == mat_pkg::CntW'(mat_pkg::DivBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      prev_q   <= '0;
      primed_q <= 1'b0;
      tick_q   <= '0;
      vel_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        if (cmd_q == mat_pkg::CmdClear) begin
          tick_q <= '0;
        end else if (raw_ok) begin
          prev_q <= raw_q[mat_pkg::AngleW-1:0];
          if (!primed_q) begin
            primed_q <= 1'b1;
          end else begin
            tick_q <= tick_q + {{(mat_pkg::TickW-mat_pkg::DeltaW){delta_q[mat_pkg::DeltaW-1]}},
                                delta_q};
          end
        end
      end
      if (cmd_i.add_half) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.apply_sign) begin
        vel_q <= delta_q[mat_pkg::DeltaW-1] ? 32'(-num_q[mat_pkg::TickW-1:0])
                                            : num_q[mat_pkg::TickW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= req_cmd_i;
      raw_q <= req_raw_angle_i;
      dt_q  <= req_dt_us_i;
    end
    if (cmd_i.calc_delta) begin
      delta_q <= delta_d;
    end
    if (cmd_i.update) begin
      taken_q <= (cmd_q == mat_pkg::CmdSample) && raw_ok;
    end
    if (cmd_i.mul) begin
      num_q <= mat_pkg::DivBits'(mag) * mat_pkg::DivBits'(mat_pkg::VelK);
    end else if (cmd_i.add_half) begin
      num_q <= num_q + mat_pkg::DivBits'(dt_q[mat_pkg::DtW-1:1]);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[mat_pkg::DivBits-2:0], fits};
      rem_q <= fits ? trial[mat_pkg::DtW-1:0] : partial[mat_pkg::DtW-1:0];
    end
    if (cmd_i.load_out) begin
      out_ticks_q <= $signed(tick_q);
      out_vel_q   <= $signed(vel_q);
      out_taken_q <= taken_q;
    end
  end

  assign total_ticks_o  = out_ticks_q;
  assign velocity_q16_o = out_vel_q;
  assign sample_taken_o = out_taken_q;

endmodule

// File: src/mat_ctrl.sv
// Controller of the angle tracker: sequences one request through the
// datapath and owns the handshake state. Depends on mat_pkg.
module mat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mat_pkg::mat_stat_t  stat_i,
  output mat_pkg::mat_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DELTA  = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_ADDH   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_SIGN   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DELTA;
      S_DELTA:  state_d = S_UPDATE;
      S_UPDATE: state_d = stat_i.vel_needed ? S_MUL : S_FINISH;
      S_MUL:    state_d = S_ADDH;
      S_ADDH:   state_d = S_DIV;
      S_DIV:    if (stat_i.div_last) state_d = S_SIGN;
      S_SIGN:   state_d = S_FINISH;
      S_FINISH: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_in    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.calc_delta = (state_q == S_DELTA);
    cmd_o.update     = (state_q == S_UPDATE);
    cmd_o.mul        = (state_q == S_MUL);
    cmd_o.add_half   = (state_q == S_ADDH);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.apply_sign = (state_q == S_SIGN);
    cmd_o.load_out   = (state_q == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DELTA))
    else $error("accepted request did not start the delta step");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !stat_i.div_last) |=> (state_q == S_DIV))
    else $error("divider left before its last step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && !$past(cmd_o.load_out)))
    else $error("pending result was overwritten");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result raised outside the finish step");

endmodule
